// ----- design/bpc_pkg.sv -----
// Package for the button press classifier.
// Holds the shared types, field widths and register indexes; no dependencies.

package bpc_pkg;

   // Width of the time stamps and of all elapsed-time arithmetic
   localparam int TIME_W = 32;

   // Field widths
   localparam int NOW_W   = 32;
   localparam int DEB_W   = 8;
   localparam int PRESS_W = 16;

   // Stream payload widths (fields packed from bit 0, padded to bytes)
   localparam int REQ_FIELDS_W = 1 + NOW_W + 1;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 4;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_DELAY   = 2'd0,
      CSR_SHORT_PRESS_TIME = 2'd1,
      CSR_LONG_PRESS_TIME  = 2'd2
   } csr_index_type;

   // Classifier mode
   typedef enum logic [1:0] {
      MODE_IDLE       = 2'd0,
      MODE_DEBOUNCING = 2'd1,
      MODE_PRESSED    = 2'd2
   } mode_type;

   // Live configuration values
   typedef struct packed {
      logic [PRESS_W-1:0] long_press_time;
      logic [PRESS_W-1:0] short_press_time;
      logic [DEB_W-1:0]   debounce_delay;
   } cfg_type;

   // One poll
   typedef struct packed {
      logic             display_on;
      logic [NOW_W-1:0] now_time;
      logic             raw_level;
   } poll_type;

   // One result, field order matches the rsp_tdata packing
   typedef struct packed {
      logic sleep_timer_reset;
      logic display_wake;
      logic long_press;
      logic short_press;
   } result_type;

endpackage

// ----- design/button_press_classifier.sv -----
// Top level of the button press classifier: stream ports, input and result registers.
// Depends on bpc_pkg, bpc_csr and bpc_core.

// Classifies polls of one active-low push button into short-press, long-press,
// display-wake and sleep-timer-reset pulses, one result transaction per poll
// transaction. A poll is registered on entry, classified by the mode logic and
// stored in the result register; a new poll is taken every cycle while the
// result side keeps up, since the mode logic updates its state in one step
// per poll. Times are compared modulo 2^32. Configuration writes take effect
// once registered and are meant for when no poll is in flight.

module button_press_classifier (
   input  logic                              clock,
   input  logic                              reset,
   // poll channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] raw_level, [32:1] now_time, [33] display_on, [39:34] zero
   input  logic [bpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] short_press, [1] long_press, [2] display_wake, [3] sleep_timer_reset,
   // [7:4] zero
   output logic [bpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                  in_valid_ff;
   bpc_pkg::poll_type     in_poll_ff;
   logic                  out_valid_ff;
   bpc_pkg::result_type   out_res_ff;

   bpc_pkg::cfg_type      cfg;
   bpc_pkg::result_type   result;
   logic                  advance;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .poll   (in_poll_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Handshake: a poll moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_poll_ff <= req_tdata[bpc_pkg::REQ_FIELDS_W-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = bpc_pkg::RSP_DATA_W'(out_res_ff);

endmodule

// ----- design/bpc_csr.sv -----
// Configuration registers of the button press classifier.
// Depends on bpc_pkg for widths, register indexes and the cfg_type struct.

module bpc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_data,
   output bpc_pkg::cfg_type                cfg
);

   bpc_pkg::cfg_type cfg_ff, cfg_in;

   // Always ready: a write goes straight into the registers
   assign csr_ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bpc_pkg::CSR_DEBOUNCE_DELAY:
               cfg_in.debounce_delay = csr_data[bpc_pkg::DEB_W-1:0];
            bpc_pkg::CSR_SHORT_PRESS_TIME:
               cfg_in.short_press_time = csr_data[bpc_pkg::PRESS_W-1:0];
            bpc_pkg::CSR_LONG_PRESS_TIME:
               cfg_in.long_press_time = csr_data[bpc_pkg::PRESS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_delay   <= bpc_pkg::DEB_W'(20);
         cfg_ff.short_press_time <= bpc_pkg::PRESS_W'(50);
         cfg_ff.long_press_time  <= bpc_pkg::PRESS_W'(1000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/bpc_core.sv -----
// Press classification state and its update for one poll.
// Depends on bpc_pkg for the mode enum and the poll, config and result structs.

module bpc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  bpc_pkg::poll_type      poll,
   input  bpc_pkg::cfg_type       cfg,
   output bpc_pkg::result_type    result
);

   bpc_pkg::mode_type                mode_ff, mode_in;
   logic [bpc_pkg::TIME_W-1:0]       deb_start_ff, deb_start_in;
   logic [bpc_pkg::TIME_W-1:0]       press_start_ff, press_start_in;
   logic                             long_done_ff, long_done_in;
   logic                             long_active_ff, long_active_in;
   logic                             hold_ff, hold_in;

   logic [bpc_pkg::TIME_W-1:0]       now;
   logic [bpc_pkg::TIME_W-1:0]       deb_elapsed;
   logic [bpc_pkg::TIME_W-1:0]       held;
   logic                             released;

   // Elapsed times wrap modulo 2^TIME_W
   assign now         = bpc_pkg::TIME_W'(poll.now_time);
   assign released    = poll.raw_level;
   assign deb_elapsed = now - deb_start_ff;
   assign held        = now - press_start_ff;

   // Next state
   always_comb begin
      mode_in        = mode_ff;
      deb_start_in   = deb_start_ff;
      press_start_in = press_start_ff;
      long_done_in   = long_done_ff;
      long_active_in = long_active_ff;
      hold_in        = hold_ff;
      unique case (mode_ff)
         bpc_pkg::MODE_DEBOUNCING: begin
            if (deb_elapsed >= bpc_pkg::TIME_W'(cfg.debounce_delay)) begin
               if (!released) begin
                  mode_in        = bpc_pkg::MODE_PRESSED;
                  press_start_in = now;
                  long_done_in   = 1'b0;
               end else begin
                  mode_in = bpc_pkg::MODE_IDLE;
               end
            end
         end
         bpc_pkg::MODE_PRESSED: begin
            priority if (!poll.display_on) begin
               mode_in = bpc_pkg::MODE_IDLE;
               hold_in = 1'b1;
            end else if (released && !long_active_ff) begin
               mode_in = bpc_pkg::MODE_IDLE;
            end else if ((!long_done_ff
                          && held >= bpc_pkg::TIME_W'(cfg.long_press_time))
                         || long_active_ff) begin
               long_active_in = !released;
               if (released) long_done_in = 1'b1;
            end else begin
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            mode_in = bpc_pkg::MODE_IDLE;
            priority if (!released && !hold_ff) begin
               mode_in      = bpc_pkg::MODE_DEBOUNCING;
               deb_start_in = now;
            end else if (released && hold_ff) begin
               hold_in = 1'b0;
            end else begin
            end
         end
      endcase
   end

   // Result pulses
   always_comb begin
      result = '0;
      unique case (mode_ff)
         bpc_pkg::MODE_DEBOUNCING: ;
         bpc_pkg::MODE_PRESSED: begin
            priority if (!poll.display_on) begin
               result.display_wake = 1'b1;
            end else if (released && !long_active_ff) begin
               result.short_press = !long_done_ff
                  && held >= bpc_pkg::TIME_W'(cfg.short_press_time);
            end else if ((!long_done_ff
                          && held >= bpc_pkg::TIME_W'(cfg.long_press_time))
                         || long_active_ff) begin
               result.long_press = 1'b1;
            end else begin
            end
         end
         default: begin
            result.sleep_timer_reset = !released;
         end
      endcase
   end

   // State registers advance once per poll
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= bpc_pkg::MODE_IDLE;
         deb_start_ff   <= '0;
         press_start_ff <= '0;
         long_done_ff   <= 1'b0;
         long_active_ff <= 1'b0;
         hold_ff        <= 1'b0;
      end else if (step) begin
         mode_ff        <= mode_in;
         deb_start_ff   <= deb_start_in;
         press_start_ff <= press_start_in;
         long_done_ff   <= long_done_in;
         long_active_ff <= long_active_in;
         hold_ff        <= hold_in;
      end
   end

   // A short press is only ever recognised on leaving the pressed mode
   a_short_from_pressed: assert property (@(posedge clock) disable iff (reset)
      step && result.short_press |-> mode_ff == bpc_pkg::MODE_PRESSED)
      else $error("short press outside pressed mode");

   // A wake request returns to idle and blocks presses until release
   a_wake_holds: assert property (@(posedge clock) disable iff (reset)
      step && result.display_wake |=> mode_ff == bpc_pkg::MODE_IDLE && hold_ff)
      else $error("wake did not set hold-until-release");

   // Sleep timer restarts come only from idle
   a_sleep_from_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.sleep_timer_reset |->
         mode_ff != bpc_pkg::MODE_DEBOUNCING && mode_ff != bpc_pkg::MODE_PRESSED)
      else $error("sleep timer reset outside idle");

   // Long-press pulses need the pressed mode
   a_long_from_pressed: assert property (@(posedge clock) disable iff (reset)
      step && result.long_press |-> mode_ff == bpc_pkg::MODE_PRESSED)
      else $error("long press outside pressed mode");

endmodule

// ----- tb/button_press_classifier_tb.sv -----
// Self-checking testbench for the button press classifier.
// Drives poll and configuration transactions, predicts every result transaction.
// Depends on bpc_pkg and button_press_classifier.

module button_press_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bpc_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;  // no register behind it
   localparam int PHASE_POLLS     = 185;
   localparam int HOLD_OFF_AT     = 120;   // result count at which the receiver backs off
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transaction
   localparam int DRAIN_CYCLES    = 4;     // idle wait after the final drain

   // Classifier prediction and the queue of pulses still awaited
   class press_scoreboard;
      bpc_pkg::cfg_type           cfg;
      bpc_pkg::mode_type          mode;
      logic [bpc_pkg::TIME_W-1:0] debounce_start;
      logic [bpc_pkg::TIME_W-1:0] press_start;
      logic                       long_done;
      logic                       long_active;
      logic                       hold_until_release;
      bpc_pkg::result_type        expected_pulses[$];
      int                         failures;
      int                         checked;
      int                         shorts, longs, wakes, sleeps;

      function new();
         cfg.debounce_delay   = 8'd20;
         cfg.short_press_time = 16'd50;
         cfg.long_press_time  = 16'd1000;
         mode               = bpc_pkg::MODE_IDLE;
         debounce_start     = '0;
         press_start        = '0;
         long_done          = 1'b0;
         long_active        = 1'b0;
         hold_until_release = 1'b0;
         failures = 0;
         checked  = 0;
         shorts = 0; longs = 0; wakes = 0; sleeps = 0;
      endfunction

      // Accepted register write; a spare index changes nothing
      function void write_reg(logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                              logic [bpc_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            bpc_pkg::CSR_DEBOUNCE_DELAY:
               cfg.debounce_delay   = val[bpc_pkg::DEB_W-1:0];
            bpc_pkg::CSR_SHORT_PRESS_TIME:
               cfg.short_press_time = val[bpc_pkg::PRESS_W-1:0];
            bpc_pkg::CSR_LONG_PRESS_TIME:
               cfg.long_press_time  = val[bpc_pkg::PRESS_W-1:0];
            default: ;
         endcase
      endfunction

      // One poll through the mode logic; all time differences wrap at 2^32
      function bpc_pkg::result_type classify(bpc_pkg::poll_type p);
         bpc_pkg::result_type        r;
         logic [bpc_pkg::TIME_W-1:0] settled;
         logic [bpc_pkg::TIME_W-1:0] held;
         logic                       released;
         r        = '0;
         released = p.raw_level;
         settled  = p.now_time - debounce_start;
         held     = p.now_time - press_start;
         case (mode)
            bpc_pkg::MODE_DEBOUNCING: begin
               if (settled >= bpc_pkg::TIME_W'(cfg.debounce_delay)) begin
                  if (!released) begin
                     mode        = bpc_pkg::MODE_PRESSED;
                     press_start = p.now_time;
                     long_done   = 1'b0;
                  end else begin
                     mode = bpc_pkg::MODE_IDLE;
                  end
               end
            end
            bpc_pkg::MODE_PRESSED: begin
               if (!p.display_on) begin
                  // wake only; long_active deliberately left alone
                  r.display_wake     = 1'b1;
                  mode               = bpc_pkg::MODE_IDLE;
                  hold_until_release = 1'b1;
               end else if (released && !long_active) begin
                  if (!long_done && held >= bpc_pkg::TIME_W'(cfg.short_press_time))
                     r.short_press = 1'b1;
                  mode = bpc_pkg::MODE_IDLE;
               end else if ((!long_done &&
                             held >= bpc_pkg::TIME_W'(cfg.long_press_time)) ||
                            long_active) begin
                  long_active = 1'b1;
                  if (released) begin
                     long_done   = 1'b1;
                     long_active = 1'b0;
                  end
                  r.long_press = 1'b1;
               end
            end
            default: begin
               // idle, and the unused code behaves the same
               mode = bpc_pkg::MODE_IDLE;
               if (!released && !hold_until_release) begin
                  r.sleep_timer_reset = 1'b1;
                  mode                = bpc_pkg::MODE_DEBOUNCING;
                  debounce_start      = p.now_time;
               end else if (released && hold_until_release) begin
                  hold_until_release = 1'b0;
               end else if (!released) begin
                  r.sleep_timer_reset = 1'b1;
               end
            end
         endcase
         return r;
      endfunction

      function void note_poll(bpc_pkg::poll_type p);
         bpc_pkg::result_type r;
         r = classify(p);
         shorts += int'(r.short_press);
         longs  += int'(r.long_press);
         wakes  += int'(r.display_wake);
         sleeps += int'(r.sleep_timer_reset);
         expected_pulses.push_back(r);
      endfunction

      function void compare_pulse(string field, logic exp_bit, logic got_bit);
         if (exp_bit !== got_bit) begin
            failures++;
            $display("%0t: %s expected %0b, got %0b", $time, field, exp_bit, got_bit);
         end
      endfunction

      function void check_result(bpc_pkg::result_type got);
         bpc_pkg::result_type exp_r;
         if (expected_pulses.size() == 0) begin
            failures++;
            $display("%0t: result %b arrived with nothing expected", $time, got);
            return;
         end
         exp_r = expected_pulses.pop_front();
         checked++;
         compare_pulse("short_press", exp_r.short_press, got.short_press);
         compare_pulse("long_press", exp_r.long_press, got.long_press);
         compare_pulse("display_wake", exp_r.display_wake, got.display_wake);
         compare_pulse("sleep_timer_reset", exp_r.sleep_timer_reset, got.sleep_timer_reset);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bpc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bpc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bpc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   press_scoreboard            sb;
   logic [bpc_pkg::NOW_W-1:0]  stamp = '0;
   int                         polls_sent = 0;
   int                         results_seen = 0;
   int                         idle_cycles = 0;
   int                         settings_used = 1;

   button_press_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait per item: mostly random, with regular stretches of none
   function automatic int draw_gap(int n);
      if ((n / 48) % 4 == 3)
         return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
   endfunction

   // Register write; valid stays up so writes can follow back to back
   task automatic write_reg(input logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpc_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_settings(input int deb, input int short_t, input int long_t);
      write_reg(bpc_pkg::CSR_DEBOUNCE_DELAY, bpc_pkg::CSR_DATA_W'(deb));
      write_reg(bpc_pkg::CSR_SHORT_PRESS_TIME, bpc_pkg::CSR_DATA_W'(short_t));
      write_reg(bpc_pkg::CSR_LONG_PRESS_TIME, bpc_pkg::CSR_DATA_W'(long_t));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Poll transaction; valid stays up across back-to-back polls
   task automatic send_poll(input logic raw, input logic [bpc_pkg::NOW_W-1:0] t,
                            input logic disp);
      bpc_pkg::poll_type p;
      int                gap;
      p.raw_level  = raw;
      p.now_time   = t;
      p.display_on = disp;
      gap = draw_gap(polls_sent);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bpc_pkg::REQ_DATA_W'(p);
      do @(posedge clock); while (!req_tready);
      sb.note_poll(p);
      polls_sent++;
   endtask

   task automatic advance_and_poll(input logic raw, input int unsigned step, input logic disp);
      stamp = stamp + bpc_pkg::NOW_W'(step);
      send_poll(raw, stamp, disp);
   endtask

   // Idle until every expected result has been checked
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_pulses.size() != 0) @(posedge clock);
   endtask

   // A well-formed press: lead-in, debounce with bounce, hold, release
   task automatic press_sequence();
      int unsigned deb, short_t, long_t, target, steps, step;
      deb     = 32'(sb.cfg.debounce_delay);
      short_t = 32'(sb.cfg.short_press_time);
      long_t  = 32'(sb.cfg.long_press_time);
      if ($urandom_range(0, 9) == 0)
         stamp = 32'hFFFF_FFFF - $urandom_range(0, 300);   // cross the wrap
      repeat ($urandom_range(0, 2)) advance_and_poll(1'b1, $urandom_range(0, 40), 1'b1);
      advance_and_poll(1'b0, $urandom_range(1, 40), 1'b1);
      repeat ($urandom_range(0, 2))
         advance_and_poll(1'($urandom_range(0, 1)), $urandom_range(0, deb / 3), 1'b1);
      // settled press, now and then still inside the window
      step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, deb / 2)
                                         : deb + $urandom_range(0, 3);
      advance_and_poll(1'b0, step, 1'b1);
      case ($urandom_range(0, 3))
         0:       target = $urandom_range(0, short_t);
         1:       target = $urandom_range(short_t, long_t);
         2:       target = long_t + $urandom_range(0, long_t / 2 + 20);
         default: target = ($urandom_range(0, 1) != 0) ? short_t : long_t;
      endcase
      steps = $urandom_range(1, 8);
      for (int i = 0; i < steps; i++) begin
         step = (i == steps - 1) ? target - (target / steps) * (steps - 1) : target / steps;
         advance_and_poll(1'b0, step, $urandom_range(0, 15) != 0);
      end
      repeat ($urandom_range(0, 4))
         advance_and_poll(1'b0, $urandom_range(0, 30), $urandom_range(0, 15) != 0);
      repeat ($urandom_range(1, 3))
         advance_and_poll(1'b1, $urandom_range(0, 30), $urandom_range(0, 15) != 0);
   endtask

   // Unstructured polls, including jumps anywhere in the time range
   task automatic noise_polls();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 7) == 0)
            stamp = $urandom;
         else
            stamp = stamp + bpc_pkg::NOW_W'($urandom_range(0, 2000));
         send_poll(1'($urandom_range(0, 1)), stamp, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_run(input int count);
      int stop_at;
      stop_at = polls_sent + count;
      while (polls_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8)
            press_sequence();
         else
            noise_polls();
      end
   endtask

   // Hand-picked polls at the reset settings
   task automatic directed_polls();
      send_poll(1'b1, 32'd0, 1'b1);              // released, nothing happens
      send_poll(1'b0, 32'hFFFF_FFF0, 1'b1);      // press opens debounce
      send_poll(1'b0, 32'hFFFF_FFFF, 1'b1);      // still settling
      send_poll(1'b0, 32'd4, 1'b1);              // settles across the wrap
      send_poll(1'b0, 32'd30, 1'b1);             // held, below short time
      send_poll(1'b1, 32'd60, 1'b1);             // short press on release
      send_poll(1'b0, 32'd100, 1'b1);
      send_poll(1'b1, 32'd110, 1'b1);            // bounce inside the window
      send_poll(1'b1, 32'd130, 1'b1);            // window over, released: back to idle
      send_poll(1'b0, 32'd200, 1'b1);
      send_poll(1'b0, 32'd220, 1'b1);
      send_poll(1'b0, 32'd1220, 1'b1);           // long press begins
      send_poll(1'b0, 32'd1230, 1'b1);
      send_poll(1'b1, 32'd1240, 1'b1);           // last long pulse on release
      send_poll(1'b1, 32'd1250, 1'b1);           // back to idle, no short press
      send_poll(1'b0, 32'd1300, 1'b1);
      send_poll(1'b0, 32'd1320, 1'b1);
      send_poll(1'b0, 32'd1330, 1'b0);           // display off: wake only
      send_poll(1'b0, 32'd1340, 1'b1);           // ignored press, sleep timer only
      send_poll(1'b1, 32'd1350, 1'b1);           // release clears the hold
      send_poll(1'b0, 32'd2000, 1'b1);
      send_poll(1'b0, 32'd2020, 1'b1);
      send_poll(1'b0, 32'd3020, 1'b1);           // long press active
      send_poll(1'b0, 32'd3030, 1'b0);           // wake while long is still active
      send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
   endtask

   // Result side: random stalls, one long hold-off to back the block up
   task automatic collect_results();
      int gap;
      forever begin
         gap = draw_gap(results_seen);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(bpc_pkg::result_type'(rsp_tdata[bpc_pkg::RSP_FIELDS_W-1:0]));
         results_seen++;
         if (results_seen == HOLD_OFF_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
      end
   endtask

   // Watchdog: ends the run when no transaction of any kind happens for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, sb.expected_pulses.size());
      $display("status: fail");
      $finish;
   end

   // Main sequence
   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none
      write_reg(CSR_SPARE_INDEX, 16'hFFFF);   // must be ignored
      csr_valid <= 1'b0;
      directed_polls();
      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1:       apply_settings(0, 0, 0);
               2:       apply_settings(255, 65535, 65535);
               3:       apply_settings($urandom_range(0, 255), $urandom_range(0, 65535),
                                       $urandom_range(0, 65535));
               default: apply_settings($urandom_range(1, 8), $urandom_range(5, 30),
                                       $urandom_range(40, 120));
            endcase
         end
         random_run(PHASE_POLLS);
      end
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d polls under %0d settings, %0d results checked, %0d mismatches.",
               polls_sent, settings_used, sb.checked, sb.failures);
      $display("Pulses seen: %0d short, %0d long, %0d wake, %0d sleep-timer restarts.",
               sb.shorts, sb.longs, sb.wakes, sb.sleeps);
      if (sb.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
